[rtl/ivm_pkg.sv]
package ivm_pkg;

	localparam int XLEN = 32;

	// data memory depth must stay a power of two: the address wrap is a plain mask
	localparam int MEM_WORDS = 4096;
	localparam int MEM_AW = $clog2(MEM_WORDS);

	localparam int NUM_REGS = 16;
	localparam int REG_IDX_W = 4;
	localparam int REG_DEPTH = 2 ** REG_IDX_W;

	localparam int MAX_PROGRAM = 1024;
	localparam int TGT_W = $clog2(MAX_PROGRAM);
	localparam int LEN_W = $clog2(MAX_PROGRAM) + 1;

	localparam int S_DATA_W = 56;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 72;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int CFG_IDX_W = APB_AW - 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN = '0;

	typedef enum logic [2:0] {
		OP_ADDI = 3'd0,
		OP_BEQ  = 3'd1,
		OP_BNE  = 3'd2,
		OP_LW   = 3'd3,
		OP_SW   = 3'd4,
		OP_JALR = 3'd5,
		OP_J    = 3'd6,
		OP_HALT = 3'd7
	} ivm_op_t;

	typedef struct packed {
		logic                 en;
		logic [REG_IDX_W-1:0] addr;
		logic [XLEN-1:0]      data;
	} ivm_rwr_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [XLEN-1:0]   data;
	} ivm_mwr_t;

	function automatic logic reg_writable(input logic [REG_IDX_W-1:0] idx);
		return (idx != '0) && (32'(idx) < NUM_REGS);
	endfunction

endpackage

[rtl/ivm_ram.sv]
module ivm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word when the same entry is written in the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/ivm_regfile.sv]
module ivm_regfile (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ivm_pkg::REG_IDX_W-1:0] raddr_a,
	input  logic [ivm_pkg::REG_IDX_W-1:0] raddr_b,
	input  ivm_pkg::ivm_rwr_t             wr,
	output logic [ivm_pkg::XLEN-1:0]      rdata_a,
	output logic [ivm_pkg::XLEN-1:0]      rdata_b
);
	import ivm_pkg::*;

	logic [REG_DEPTH-1:0] valid_q;
	logic [REG_IDX_W-1:0] addr_a_q;
	logic [REG_IDX_W-1:0] addr_b_q;
	ivm_rwr_t             last_q;
	logic [XLEN-1:0]      ram_a;
	logic [XLEN-1:0]      ram_b;

	// two copies so both source registers come out in the same cycle
	ivm_ram #(.WIDTH(XLEN), .DEPTH(REG_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr_a),
		.rdata (ram_a)
	);

	ivm_ram #(.WIDTH(XLEN), .DEPTH(REG_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr_b),
		.rdata (ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			last_q  <= '0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			last_q <= wr;
		end
	end

	always_ff @(posedge clk) begin
		addr_a_q <= raddr_a;
		addr_b_q <= raddr_b;
	end

	// a write on the read edge is missed by the ram, so take it from last_q
	always_comb begin
		if (last_q.en && last_q.addr == addr_a_q) begin
			rdata_a = last_q.data;
		end else if (valid_q[addr_a_q]) begin
			rdata_a = ram_a;
		end else begin
			rdata_a = '0;
		end
		if (last_q.en && last_q.addr == addr_b_q) begin
			rdata_b = last_q.data;
		end else if (valid_q[addr_b_q]) begin
			rdata_b = ram_b;
		end else begin
			rdata_b = '0;
		end
	end

endmodule

[rtl/ivm_dmem.sv]
module ivm_dmem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ivm_pkg::MEM_AW-1:0] raddr,
	input  ivm_pkg::ivm_mwr_t          wr,
	output logic [ivm_pkg::XLEN-1:0]   rdata,
	output logic                       busy
);
	import ivm_pkg::*;

	logic              clearing_q;
	logic [MEM_AW-1:0] clr_idx_q;
	ivm_mwr_t          port;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == MEM_AW'(MEM_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// zero sweep owns the write port until every word is cleared
	always_comb begin
		if (clearing_q) begin
			port.en   = 1'b1;
			port.addr = clr_idx_q;
			port.data = '0;
		end else begin
			port = wr;
		end
	end

	ivm_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_ram (
		.clk   (clk),
		.we    (port.en),
		.waddr (port.addr),
		.wdata (port.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy = clearing_q;

endmodule

[rtl/integer_vm_execute_step.sv]
// Executes one decoded instruction per input beat (addi, beq, bne, lw, sw, jalr, j, halt)
// against a 16 x 32-bit register file, a 4096-word data memory and the program counter,
// returning one result beat with the next counter, the stop flag and any register write.
// The pipeline has three stages (execute, memory return and write-back, output register),
// and each result passes execute and memory return before the output register. One
// instruction can be accepted every cycle unless m_tready, a load-use wait or the memory
// sweep holds it. An instruction whose source fields name the register loaded by the lw
// just ahead of it waits in execute, because the loaded word only comes out of the data
// memory read port during that lw's second stage and is not forwarded into execute. After
// reset the data memory is swept to zero, one word per cycle, so s_tready stays low until
// the sweep ends; the config port works throughout. program_length lives at byte address 0.
module integer_vm_execute_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// dest_reg, src_reg_a, src_reg_b, immediate, branch_target, zero pad
	input  logic [ivm_pkg::S_DATA_W-1:0] s_tdata,
	// req_type
	input  logic [ivm_pkg::S_USER_W-1:0] s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// next_pc, stopped, reg_written, written_reg, written_value, zero pad
	output logic [ivm_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ivm_pkg::APB_AW-1:0]   paddr,
	input  logic [ivm_pkg::APB_DW-1:0]   pwdata,
	output logic [ivm_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import ivm_pkg::*;

	// input beat fields
	logic [REG_IDX_W-1:0] in_rd;
	logic [REG_IDX_W-1:0] in_ra;
	logic [REG_IDX_W-1:0] in_rb;
	logic [XLEN-1:0]      in_imm;
	logic [TGT_W-1:0]     in_tgt;

	assign in_rd  = s_tdata[3:0];
	assign in_ra  = s_tdata[7:4];
	assign in_rb  = s_tdata[11:8];
	assign in_imm = s_tdata[43:12];
	assign in_tgt = s_tdata[53:44];

	// configuration
	logic [LEN_W-1:0] prog_len_q;
	logic             cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = paddr[APB_AW-1:2] == CFG_PROG_LEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_len_q <= '0;
		end else if (psel && penable && pwrite && pready && cfg_hit) begin
			prog_len_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = cfg_hit ? {{(APB_DW - LEN_W){1'b0}}, prog_len_q} : '0;

	// pipeline registers
	logic                 s1_valid_q;
	ivm_op_t              op_s1;
	logic [REG_IDX_W-1:0] rd_s1;
	logic [REG_IDX_W-1:0] ra_s1;
	logic [REG_IDX_W-1:0] rb_s1;
	logic [XLEN-1:0]      imm_s1;
	logic [TGT_W-1:0]     tgt_s1;

	logic                 s2_valid_q;
	logic                 lw_s2;
	logic                 wrote_s2;
	logic [REG_IDX_W-1:0] rd_s2;
	logic [XLEN-1:0]      wval_s2;
	logic [XLEN-1:0]      next_s2;
	logic                 stop_s2;
	logic [MEM_AW-1:0]    maddr_s2;

	logic                 out_valid_q;
	logic [M_DATA_W-1:0]  out_q;

	logic [XLEN-1:0]      pc_q;

	// handshake
	logic accept;
	logic load_use;
	logic s1_adv;
	logic s2_adv;
	logic mem_busy;

	assign s2_adv   = s2_valid_q && (!out_valid_q || m_tready);
	assign load_use = s2_valid_q && lw_s2 && wrote_s2 && (rd_s2 == ra_s1 || rd_s2 == rb_s1);
	assign s1_adv   = s1_valid_q && !load_use && (!s2_valid_q || s2_adv);
	assign s_tready = !mem_busy && (!s1_valid_q || s1_adv);
	assign accept   = s_tvalid && s_tready;

	// register file, re-read at the held addresses while execute stalls
	logic [REG_IDX_W-1:0] rf_raddr_a;
	logic [REG_IDX_W-1:0] rf_raddr_b;
	logic [XLEN-1:0]      rf_a;
	logic [XLEN-1:0]      rf_b;
	ivm_rwr_t             rf_wr;
	logic [XLEN-1:0]      val_s2;
	logic [XLEN-1:0]      dmem_rdata;

	assign rf_raddr_a = (s1_valid_q && !s1_adv) ? ra_s1 : in_ra;
	assign rf_raddr_b = (s1_valid_q && !s1_adv) ? rb_s1 : in_rb;

	assign val_s2     = lw_s2 ? dmem_rdata : wval_s2;
	assign rf_wr.en   = s2_adv && wrote_s2;
	assign rf_wr.addr = rd_s2;
	assign rf_wr.data = val_s2;

	ivm_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.raddr_a (rf_raddr_a),
		.raddr_b (rf_raddr_b),
		.wr      (rf_wr),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	// execute
	logic            fwd_ok;
	logic [XLEN-1:0] src_a;
	logic [XLEN-1:0] src_b;
	logic [XLEN-1:0] sum_ai;
	logic [XLEN-1:0] pc_inc;
	logic [XLEN-1:0] tgt_ext;
	logic [XLEN-1:0] next_pc;
	logic [XLEN-1:0] wval;
	logic            wrote;
	logic            halted;
	logic            stopped;
	ivm_mwr_t        dmem_wr;
	logic [MEM_AW-1:0] dmem_raddr;

	// the instruction ahead has not written back yet: forward its value
	assign fwd_ok  = s2_valid_q && wrote_s2 && !lw_s2;
	assign src_a   = (fwd_ok && rd_s2 == ra_s1) ? wval_s2 : rf_a;
	assign src_b   = (fwd_ok && rd_s2 == rb_s1) ? wval_s2 : rf_b;
	assign sum_ai  = src_a + imm_s1;
	assign pc_inc  = pc_q + 1'b1;
	assign tgt_ext = {{(XLEN - TGT_W){1'b0}}, tgt_s1};

	always_comb begin
		next_pc = pc_inc;
		wval    = '0;
		wrote   = 1'b0;
		halted  = 1'b0;
		unique case (op_s1)
			OP_ADDI: begin
				wval  = sum_ai;
				wrote = reg_writable(rd_s1);
			end
			OP_BEQ: begin
				if (src_a == src_b) begin
					next_pc = tgt_ext;
				end
			end
			OP_BNE: begin
				if (src_a != src_b) begin
					next_pc = tgt_ext;
				end
			end
			OP_LW: begin
				wrote = reg_writable(rd_s1);
			end
			OP_SW: begin
			end
			OP_JALR: begin
				wval    = pc_inc;
				next_pc = sum_ai;
				wrote   = reg_writable(rd_s1);
			end
			OP_J: begin
				next_pc = tgt_ext;
			end
			OP_HALT: begin
				next_pc = pc_q;
				halted  = 1'b1;
			end
		endcase
	end

	assign stopped = halted || next_pc[XLEN-1] ||
		(next_pc >= {{(XLEN - LEN_W){1'b0}}, prog_len_q});

	// word address wraps modulo the memory size, negative sums included
	assign dmem_wr.en   = s1_adv && op_s1 == OP_SW;
	assign dmem_wr.addr = sum_ai[MEM_AW-1:0];
	assign dmem_wr.data = src_b;
	assign dmem_raddr   = (s2_valid_q && !s2_adv) ? maddr_s2 : sum_ai[MEM_AW-1:0];

	ivm_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (dmem_raddr),
		.wr     (dmem_wr),
		.rdata  (dmem_rdata),
		.busy   (mem_busy)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
				pc_q       <= next_pc;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= ivm_op_t'(s_tuser[2:0]);
			rd_s1  <= in_rd;
			ra_s1  <= in_ra;
			rb_s1  <= in_rb;
			imm_s1 <= in_imm;
			tgt_s1 <= in_tgt;
		end
		if (s1_adv) begin
			lw_s2    <= op_s1 == OP_LW;
			wrote_s2 <= wrote;
			rd_s2    <= rd_s1;
			wval_s2  <= wval;
			next_s2  <= next_pc;
			stop_s2  <= stopped;
			maddr_s2 <= sum_ai[MEM_AW-1:0];
		end
		if (s2_adv) begin
			out_q <= {
				{(M_DATA_W - 2 * XLEN - REG_IDX_W - 2){1'b0}},
				wrote_s2 ? val_s2 : {XLEN{1'b0}},
				wrote_s2 ? rd_s2 : {REG_IDX_W{1'b0}},
				wrote_s2,
				stop_s2,
				next_s2
			};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

[rtl/ivm_chk.sv]
module ivm_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ivm_pkg::M_DATA_W-1:0] m_tdata
);
	import ivm_pkg::*;

	logic                 out_wrote;
	logic                 out_stop;
	logic [XLEN-1:0]      out_pc;
	logic [REG_IDX_W-1:0] out_reg;
	logic [XLEN-1:0]      out_val;

	assign out_pc    = m_tdata[31:0];
	assign out_stop  = m_tdata[32];
	assign out_wrote = m_tdata[33];
	assign out_reg   = m_tdata[37:34];
	assign out_val   = m_tdata[69:38];

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_no_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !out_wrote |-> out_reg == '0 && out_val == '0)
		else $error("write fields set without a register write");

	// register zero is never reported as written
	a_no_zero_reg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_wrote |-> out_reg != '0)
		else $error("register zero reported as written");

	a_neg_pc_stops: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_pc[XLEN-1] |-> out_stop)
		else $error("negative counter without stop");

endmodule

bind integer_vm_execute_step ivm_chk u_ivm_chk (.*);
